// ===== src/mdrs_pkg.sv =====
// shared types and constants for the manhattan distance rank sort block
// map bounds, fixed field widths, command and register codes
// no dependencies
package mdrs_pkg;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned LAT_W  = 25;
  localparam int unsigned LON_W  = 26;
  localparam int unsigned RANK_W = 10;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned DIST_W = 13;

  localparam int unsigned S_TDATA_W = 64;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 24;
  localparam int unsigned M_TUSER_W = 1;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] REG_CURSOR_X = 2'd0;
  localparam logic [1:0] REG_CURSOR_Y = 2'd1;
  localparam logic [1:0] REG_VIEW_X   = 2'd2;
  localparam logic [1:0] REG_VIEW_Y   = 2'd3;

  localparam logic [8:0]  CURSOR_X_RST = 9'd210;
  localparam logic [8:0]  CURSOR_Y_RST = 9'd160;
  localparam logic [10:0] VIEW_X_RST   = 11'd814;
  localparam logic [10:0] VIEW_Y_RST   = 11'd864;

  // map bounds in hundred-thousandths of a degree
  localparam logic signed [LAT_W:0] BOUND_N = 26'sd5361858;
  localparam logic signed [LAT_W:0] BOUND_S = 26'sd5340953;
  localparam logic signed [LON_W:0] BOUND_W = -27'sd11368652;
  localparam logic signed [LON_W:0] BOUND_E = -27'sd11333496;

  localparam int unsigned LON_SPAN = 35156;
  localparam int unsigned LAT_SPAN = 20905;
  localparam int unsigned DLON_W   = 16;
  localparam int unsigned DLAT_W   = 15;

  localparam int unsigned MAP_SIZE = 2048;
  localparam int unsigned DIST_MAX = 4096;
  localparam int unsigned PX_W     = 13;
  localparam int unsigned CUR_W    = 12;

  // reciprocal division: scaled value stays below 2**DIV_SHIFT
  localparam int unsigned X_W       = 28;
  localparam int unsigned DIV_SHIFT = 28;
  localparam int unsigned RECIP_W   = 14;
  localparam longint unsigned LON_RECIP = (64'd1 << DIV_SHIFT) / LON_SPAN;
  localparam longint unsigned LAT_RECIP = (64'd1 << DIV_SHIFT) / LAT_SPAN;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  idx;
  } mdrs_entry_t;

endpackage

// ===== src/mdrs_dist.sv =====
// coordinate clamp, pixel scaling and manhattan distance pipeline
// five stages, reciprocal multiply with one correction step per axis
// depends on mdrs_pkg
module mdrs_dist import mdrs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [LAT_W-1:0] lat_i,
  input  logic signed [LON_W-1:0] lon_i,
  input  logic [CUR_W-1:0]        cur_x_i,
  input  logic [CUR_W-1:0]        cur_y_i,
  output logic                    valid_o,
  output logic [DIST_W-1:0]       dist_o
);

  localparam int unsigned PROD_W = X_W + RECIP_W;

  logic [4:0] vld_q;

  logic signed [LON_W:0] lon_ext, lon_cl, lon_off;
  logic signed [LAT_W:0] lat_ext, lat_cl, lat_off;

  logic [DLON_W-1:0] dlon_q;
  logic [DLAT_W-1:0] dlat_q;
  logic [X_W-1:0]    xlon_q, xlat_q, xlon2_q, xlat2_q;
  logic [PROD_W-1:0] plon, plat;
  logic [PX_W-1:0]   qlon_q, qlat_q, pxlon_q, pxlat_q;
  logic [X_W-1:0]    blon, blat, rlon, rlat;
  logic [PX_W-1:0]   cx, cy, ax, ay;
  logic [PX_W:0]     sum;
  logic [DIST_W-1:0] dist_q;

  // clamp to bounds
  always_comb begin
    lon_ext = {lon_i[LON_W-1], lon_i};
    lat_ext = {lat_i[LAT_W-1], lat_i};
    if (lon_ext < BOUND_W) begin
      lon_cl = BOUND_W;
    end else if (lon_ext > BOUND_E) begin
      lon_cl = BOUND_E;
    end else begin
      lon_cl = lon_ext;
    end
    if (lat_ext < BOUND_S) begin
      lat_cl = BOUND_S;
    end else if (lat_ext > BOUND_N) begin
      lat_cl = BOUND_N;
    end else begin
      lat_cl = lat_ext;
    end
    lon_off = lon_cl - BOUND_W;
    lat_off = BOUND_N - lat_cl;
  end

  assign plon = PROD_W'(xlon_q) * PROD_W'(LON_RECIP);
  assign plat = PROD_W'(xlat_q) * PROD_W'(LAT_RECIP);

  assign blon = X_W'(qlon_q) * X_W'(LON_SPAN);
  assign blat = X_W'(qlat_q) * X_W'(LAT_SPAN);
  assign rlon = xlon2_q - blon;
  assign rlat = xlat2_q - blat;

  assign cx  = PX_W'(cur_x_i);
  assign cy  = PX_W'(cur_y_i);
  assign ax  = (cx >= pxlon_q) ? (cx - pxlon_q) : (pxlon_q - cx);
  assign ay  = (cy >= pxlat_q) ? (cy - pxlat_q) : (pxlat_q - cy);
  assign sum = (PX_W+1)'(ax) + (PX_W+1)'(ay);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    dlon_q  <= lon_off[DLON_W-1:0];
    dlat_q  <= lat_off[DLAT_W-1:0];
    xlon_q  <= X_W'(dlon_q) * X_W'(MAP_SIZE);
    xlat_q  <= X_W'(dlat_q) * X_W'(MAP_SIZE);
    qlon_q  <= plon[DIV_SHIFT +: PX_W];
    qlat_q  <= plat[DIV_SHIFT +: PX_W];
    xlon2_q <= xlon_q;
    xlat2_q <= xlat_q;
    pxlon_q <= qlon_q + PX_W'(rlon >= X_W'(LON_SPAN));
    pxlat_q <= qlat_q + PX_W'(rlat >= X_W'(LAT_SPAN));
    dist_q  <= (sum > (PX_W+1)'(DIST_MAX)) ? DIST_W'(DIST_MAX) : DIST_W'(sum);
  end

  assign valid_o = vld_q[4];
  assign dist_o  = dist_q;

  a_dist_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> dist_o <= DIST_W'(DIST_MAX))
    else $error("distance above saturation limit");

  a_px_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> (pxlon_q <= PX_W'(MAP_SIZE)) && (pxlat_q <= PX_W'(MAP_SIZE)))
    else $error("pixel coordinate outside map");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (rlon < X_W'(2 * LON_SPAN)) && (rlat < X_W'(2 * LAT_SPAN)))
    else $error("reciprocal estimate off by more than one");

endmodule

// ===== src/manhattan_distance_rank_sort.sv =====
// Ranks loaded points by manhattan distance to the cursor in a sorted table memory.
// A clear resets the entry count, a read fetches the ranked entry and waits for the
// output to drain, a load waits for the distance pipeline and, on a non-empty table,
// then shifts every stored entry with a larger distance up by one slot; that shift is
// set by the single write port of the table memory. One request is worked at a
// time. Loads on a full table are dropped, the table needs no clearing pass.
// depends on mdrs_pkg and mdrs_dist
module manhattan_distance_rank_sort import mdrs_pkg::*; #(
  parameter int unsigned NUM_ENTRIES = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // lat [24:0], lon [50:25], rank [60:51]
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // cmd [1:0]
  input  logic [S_TUSER_W-1:0]  s_axis_tuser,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // entry_index [9:0], distance [22:10]
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  // rank_valid [0]
  output logic [M_TUSER_W-1:0]  m_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready
);

  localparam int unsigned AW    = $clog2(NUM_ENTRIES);
  localparam int unsigned CNT_W = $clog2(NUM_ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIST = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_INS  = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [AW-1:0]    ptr_q, ptr_d, ptr_m1, ptr_m2;
  logic [DIST_W-1:0] d_q, d_d;
  logic             rank_ok_q, rank_ok_d;

  logic [8:0]  cursor_x_q, cursor_y_q;
  logic [10:0] view_x_q, view_y_q;

  logic             m_valid_q;
  logic [IDX_W-1:0] m_idx_q;
  logic [DIST_W-1:0] m_dist_q;
  logic             m_ok_q;
  logic             out_free, out_load;

  mdrs_entry_t tbl_mem [NUM_ENTRIES];
  mdrs_entry_t mem_rdata_q, mem_wdata;
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;

  logic [CMD_W-1:0]        cmd;
  logic signed [LAT_W-1:0] lat;
  logic signed [LON_W-1:0] lon;
  logic [RANK_W-1:0]       rank;
  logic                    s_acc, full, dist_start, dist_vld, cfg_we;
  logic [DIST_W-1:0]       load_dist;
  logic [CUR_W-1:0]        cur_x, cur_y;
  logic [IDX_W-1:0]        new_idx;

  assign cmd  = s_axis_tuser[CMD_W-1:0];
  assign lat  = s_axis_tdata[LAT_W-1:0];
  assign lon  = s_axis_tdata[LAT_W +: LON_W];
  assign rank = s_axis_tdata[LAT_W+LON_W +: RANK_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CNT_W'(NUM_ENTRIES));
  assign dist_start    = s_acc && (cmd == CMD_LOAD) && !full;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign new_idx       = IDX_W'(count_q);
  assign ptr_m1        = ptr_q - 1'b1;
  assign ptr_m2        = ptr_m1 - 1'b1;

  assign cur_x = CUR_W'(view_x_q) + CUR_W'(cursor_x_q);
  assign cur_y = CUR_W'(view_y_q) + CUR_W'(cursor_y_q);

  mdrs_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dist_start),
    .lat_i   (lat),
    .lon_i   (lon),
    .cur_x_i (cur_x),
    .cur_y_i (cur_y),
    .valid_o (dist_vld),
    .dist_o  (load_dist)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    d_d       = d_q;
    rank_ok_d = rank_ok_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = ptr_q;
    mem_raddr = ptr_m1;
    mem_wdata = '{distance: d_q, idx: new_idx};
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          unique case (cmd)
            CMD_CLEAR: count_d = '0;
            CMD_LOAD: begin
              if (!full) begin
                state_d = ST_DIST;
              end
            end
            CMD_READ: begin
              mem_re    = 1'b1;
              mem_raddr = AW'(rank);
              rank_ok_d = CMP_W'(rank) < CMP_W'(count_q);
              state_d   = ST_RD;
            end
            default: ;
          endcase
        end
      end
      ST_DIST: begin
        if (dist_vld) begin
          d_d = load_dist;
          if (count_q == '0) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = '{distance: load_dist, idx: new_idx};
            count_d   = count_q + 1'b1;
            state_d   = ST_IDLE;
          end else begin
            ptr_d     = AW'(count_q);
            mem_re    = 1'b1;
            mem_raddr = AW'(count_q - 1'b1);
            state_d   = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        mem_we = 1'b1;
        if (mem_rdata_q.distance > d_q) begin
          mem_wdata = mem_rdata_q;
          if (ptr_q == AW'(1)) begin
            ptr_d   = '0;
            state_d = ST_INS;
          end else begin
            ptr_d     = ptr_m1;
            mem_re    = 1'b1;
            mem_raddr = ptr_m2;
          end
        end else begin
          count_d = count_q + 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_INS: begin
        mem_we  = 1'b1;
        count_d = count_q + 1'b1;
        state_d = ST_IDLE;
      end
      ST_RD: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= tbl_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      ptr_q     <= '0;
      d_q       <= '0;
      rank_ok_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      d_q       <= d_d;
      rank_ok_q <= rank_ok_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_ok_q   <= rank_ok_q;
      m_idx_q  <= rank_ok_q ? mem_rdata_q.idx : '0;
      m_dist_q <= rank_ok_q ? mem_rdata_q.distance : '0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_dist_q, m_idx_q};
  assign m_axis_tuser  = m_ok_q;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= CURSOR_X_RST;
      cursor_y_q <= CURSOR_Y_RST;
      view_x_q   <= VIEW_X_RST;
      view_y_q   <= VIEW_Y_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_CURSOR_X: cursor_x_q <= pwdata[8:0];
        REG_CURSOR_Y: cursor_y_q <= pwdata[8:0];
        REG_VIEW_X:   view_x_q   <= pwdata[10:0];
        REG_VIEW_Y:   view_y_q   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CURSOR_X: prdata = APB_DW'(cursor_x_q);
      REG_CURSOR_Y: prdata = APB_DW'(cursor_y_q);
      REG_VIEW_X:   prdata = APB_DW'(view_x_q);
      REG_VIEW_Y:   prdata = APB_DW'(view_y_q);
      default:      prdata = '0;
    endcase
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(NUM_ENTRIES))
    else $error("entry count above table depth");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("table read and write hit the same entry");

  a_dist_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_vld |-> state_q == ST_DIST)
    else $error("distance result outside load wait");

  a_bad_rank_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && !m_ok_q |-> (m_idx_q == '0) && (m_dist_q == '0))
    else $error("out of range rank with nonzero fields");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) && (count_q != '0) |-> count_q == $past(count_q) + 1'b1)
    else $error("entry count moved by more than one");

endmodule

// ===== dv/manhattan_distance_rank_sort_tb.sv =====
`timescale 1ns / 100ps
// testbench for manhattan_distance_rank_sort: random and directed clear, load and read
// requests, results checked against a built-in predictor of the sorted distance table
// depends on mdrs_pkg and the manhattan_distance_rank_sort rtl
module manhattan_distance_rank_sort_tb;
  import mdrs_pkg::*;

  localparam int unsigned NUM_ENTRIES    = 1024;
  localparam int unsigned SETTLE_CYCLES  = NUM_ENTRIES + 16;
  localparam int unsigned WATCHDOG_LIMIT = 20 * SETTLE_CYCLES;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [LAT_W-1:0]  lat;
    logic [LON_W-1:0]  lon;
    logic [RANK_W-1:0] rank;
  } ranking_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]  entry_index;
    logic [DIST_W-1:0] distance;
    logic              rank_valid;
  } rank_reply_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [APB_AW-1:0]    paddr = '0;
  logic [APB_DW-1:0]    pwdata = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  manhattan_distance_rank_sort #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [IDX_W-1:0]  rank_idx [NUM_ENTRIES];
  logic [DIST_W-1:0] rank_dist[NUM_ENTRIES];
  int unsigned       point_count = 0;
  logic [8:0]        cursor_col = CURSOR_X_RST;
  logic [8:0]        cursor_row = CURSOR_Y_RST;
  logic [10:0]       view_col = VIEW_X_RST;
  logic [10:0]       view_row = VIEW_Y_RST;

  ranking_req_t      pending_reqs[$];
  rank_reply_t       expected_ranks[$];
  logic [LAT_W+LON_W-1:0] recent_spots[$];
  int unsigned       fail_count = 0;
  int unsigned       idle_cycles = 0;
  bit                s_taken = 1'b0;
  bit                sender_gaps_on = 1'b1;
  bit                receiver_stalls_on = 1'b1;
  int unsigned       burst_left = 0;
  int unsigned       gap_left = 0;
  logic [15:0]       stall_pattern = 16'hffff;
  int unsigned       pattern_age = 0;

  function automatic logic [DIST_W-1:0] map_distance(logic signed [LAT_W-1:0] lat,
                                                     logic signed [LON_W-1:0] lon);
    longint lat_v, lon_v, col, row, cur_col, cur_row, dist_v;
    lat_v = longint'(lat);
    lon_v = longint'(lon);
    if (lon_v < longint'(BOUND_W)) lon_v = longint'(BOUND_W);
    if (lon_v > longint'(BOUND_E)) lon_v = longint'(BOUND_E);
    if (lat_v < longint'(BOUND_S)) lat_v = longint'(BOUND_S);
    if (lat_v > longint'(BOUND_N)) lat_v = longint'(BOUND_N);
    col = (lon_v - longint'(BOUND_W)) * longint'(MAP_SIZE) /
          (longint'(BOUND_E) - longint'(BOUND_W));
    row = (longint'(BOUND_N) - lat_v) * longint'(MAP_SIZE) /
          (longint'(BOUND_N) - longint'(BOUND_S));
    cur_col = longint'(view_col) + longint'(cursor_col);
    cur_row = longint'(view_row) + longint'(cursor_row);
    dist_v = (cur_col > col ? cur_col - col : col - cur_col) +
             (cur_row > row ? cur_row - row : row - cur_row);
    if (dist_v > longint'(DIST_MAX)) dist_v = longint'(DIST_MAX);
    return dist_v[DIST_W-1:0];
  endfunction

  // stable insertion: after every entry with a distance not above the new one
  task automatic insert_point(logic [DIST_W-1:0] new_dist);
    int unsigned pos, k;
    if (point_count >= NUM_ENTRIES) return;
    pos = point_count;
    while (pos > 0 && rank_dist[pos-1] > new_dist) pos--;
    for (k = point_count; k > pos; k--) begin
      rank_idx[k]  = rank_idx[k-1];
      rank_dist[k] = rank_dist[k-1];
    end
    rank_idx[pos]  = point_count[IDX_W-1:0];
    rank_dist[pos] = new_dist;
    point_count++;
  endtask

  task automatic predict_request(logic [CMD_W-1:0] cmd, logic [LAT_W-1:0] lat,
                                 logic [LON_W-1:0] lon, logic [RANK_W-1:0] rank);
    rank_reply_t reply;
    case (cmd)
      CMD_CLEAR: point_count = 0;
      CMD_LOAD:  insert_point(map_distance(lat, lon));
      CMD_READ: begin
        reply = '0;
        if (rank < point_count) reply = {rank_idx[rank], rank_dist[rank], 1'b1};
        expected_ranks.push_back(reply);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // monitor: results first, then the request accepted at this edge
  always @(posedge clk_i) begin
    rank_reply_t want;
    bit m_fire;
    if (rst_ni) begin
      s_taken = s_axis_tvalid && s_axis_tready;
      m_fire  = m_axis_tvalid && m_axis_tready;
      if (m_fire) begin
        if (expected_ranks.size() == 0) begin
          $error("result with no read request pending");
          fail_count++;
        end else begin
          want = expected_ranks.pop_front();
          check_field("entry_index", 32'(want.entry_index), 32'(m_axis_tdata[IDX_W-1:0]));
          check_field("distance", 32'(want.distance),
                      32'(m_axis_tdata[IDX_W+DIST_W-1:IDX_W]));
          check_field("rank_valid", 32'(want.rank_valid), 32'(m_axis_tuser[0]));
        end
      end
      if (s_taken)
        predict_request(s_axis_tuser[CMD_W-1:0], s_axis_tdata[LAT_W-1:0],
                        s_axis_tdata[LAT_W+LON_W-1:LAT_W],
                        s_axis_tdata[LAT_W+LON_W+RANK_W-1:LAT_W+LON_W]);
      if (s_taken || m_fire) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  // request driver: bursts with gaps in between
  always @(negedge clk_i) begin
    ranking_req_t req;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_taken) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = sender_gaps_on ? $urandom_range(1, 8) : 0;
      end
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        req = pending_reqs.pop_front();
        s_axis_tdata  <= {3'b000, req.rank, req.lon, req.lat};
        s_axis_tuser  <= req.cmd;
        s_axis_tvalid <= 1'b1;
        burst_left--;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result side stalls on a rotating pattern
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (pattern_age == 0) begin
        pattern_age = 48;
        stall_pattern = $urandom_range(0, 1) ? (16'($urandom) | 16'h0101)
                                             : ((16'($urandom) & 16'($urandom)) | 16'h8001);
      end
      pattern_age--;
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      m_axis_tready <= receiver_stalls_on ? stall_pattern[0] : 1'b1;
    end
  end

  task automatic push_req(logic [CMD_W-1:0] cmd, logic [LAT_W-1:0] lat,
                          logic [LON_W-1:0] lon, logic [RANK_W-1:0] rank);
    pending_reqs.push_back('{cmd: cmd, lat: lat, lon: lon, rank: rank});
  endtask

  task automatic push_read(logic [RANK_W-1:0] rank);
    push_req(CMD_READ, LAT_W'($urandom), LON_W'($urandom), rank);
  endtask

  function automatic logic [LAT_W-1:0] random_lat();
    longint v;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) v = longint'(BOUND_S) + $urandom_range(0, LAT_SPAN);
    else if (sel < 80) v = $urandom_range(0, 1) ? longint'(BOUND_N) + $urandom_range(1, 200000)
                                                 : longint'(BOUND_S) - $urandom_range(1, 200000);
    else if (sel < 92) v = longint'($urandom);
    else v = $urandom_range(0, 1) ? 64'sd9000000 : -64'sd9000000;
    return v[LAT_W-1:0];
  endfunction

  function automatic logic [LON_W-1:0] random_lon();
    longint v;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) v = longint'(BOUND_W) + $urandom_range(0, LON_SPAN);
    else if (sel < 80) v = $urandom_range(0, 1) ? longint'(BOUND_E) + $urandom_range(1, 400000)
                                                 : longint'(BOUND_W) - $urandom_range(1, 400000);
    else if (sel < 92) v = longint'($urandom);
    else v = $urandom_range(0, 1) ? 64'sd18000000 : -64'sd18000000;
    return v[LON_W-1:0];
  endfunction

  // repeats a recent point now and then so that equal distances occur
  task automatic push_random_load();
    logic [LAT_W+LON_W-1:0] spot;
    if (recent_spots.size() != 0 && $urandom_range(0, 99) < 15) begin
      spot = recent_spots[$urandom_range(0, recent_spots.size() - 1)];
    end else begin
      spot = {random_lon(), random_lat()};
      recent_spots.push_back(spot);
      if (recent_spots.size() > 8) void'(recent_spots.pop_front());
    end
    push_req(CMD_LOAD, spot[LAT_W-1:0], spot[LAT_W+LON_W-1:LAT_W], RANK_W'($urandom));
  endtask

  function automatic logic [RANK_W-1:0] pick_rank(int unsigned plan_count);
    if ($urandom_range(0, 99) < 80)
      return RANK_W'($urandom_range(0, plan_count < 1023 ? plan_count : 1023));
    return RANK_W'($urandom_range(0, 1023));
  endfunction

  // episodes of optional clear, loads with reads mixed in, then a run of reads
  task automatic queue_random_mix(int unsigned n);
    int unsigned plan_count, made, loads, reads, k;
    plan_count = point_count;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 99) < 25) begin
        push_req(CMD_CLEAR, LAT_W'($urandom), LON_W'($urandom), RANK_W'($urandom));
        plan_count = 0;
        made++;
      end
      loads = $urandom_range(1, 30);
      for (k = 0; k < loads; k++) begin
        if ($urandom_range(0, 99) < 10) begin
          push_read(pick_rank(plan_count));
        end else begin
          push_random_load();
          if (plan_count < NUM_ENTRIES) plan_count++;
        end
        if ($urandom_range(0, 99) < 5)
          push_req(CMD_UNUSED, LAT_W'($urandom), LON_W'($urandom), RANK_W'($urandom));
        made++;
      end
      reads = $urandom_range(1, 12);
      for (k = 0; k < reads; k++) push_read(pick_rank(plan_count));
      made += reads;
    end
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_ranks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] sel_reg, logic [APB_DW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel_reg, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel_reg)
      REG_CURSOR_X: cursor_col = value[8:0];
      REG_CURSOR_Y: cursor_row = value[8:0];
      REG_VIEW_X:   view_col = value[10:0];
      REG_VIEW_Y:   view_row = value[10:0];
      default: ;
    endcase
  endtask

  task automatic check_reg(logic [1:0] sel_reg, logic [APB_DW-1:0] want);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {sel_reg, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    check_field("prdata", want, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_view(logic [8:0] cx, logic [8:0] cy, logic [10:0] vx, logic [10:0] vy);
    write_reg(REG_CURSOR_X, APB_DW'(cx));
    write_reg(REG_CURSOR_Y, APB_DW'(cy));
    write_reg(REG_VIEW_X, APB_DW'(vx));
    write_reg(REG_VIEW_Y, APB_DW'(vy));
    check_reg(REG_CURSOR_X, APB_DW'(cursor_col));
    check_reg(REG_CURSOR_Y, APB_DW'(cursor_row));
    check_reg(REG_VIEW_X, APB_DW'(view_col));
    check_reg(REG_VIEW_Y, APB_DW'(view_row));
  endtask

  initial begin
    int unsigned k, phase;
    longint lat_v, lon_v;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    check_reg(REG_CURSOR_X, APB_DW'(CURSOR_X_RST));
    check_reg(REG_CURSOR_Y, APB_DW'(CURSOR_Y_RST));
    check_reg(REG_VIEW_X, APB_DW'(VIEW_X_RST));
    check_reg(REG_VIEW_Y, APB_DW'(VIEW_Y_RST));

    // empty table, unused command, corners, clamping, raw bit extremes, ties
    push_read(RANK_W'(0));
    push_read(RANK_W'(1023));
    push_req(CMD_UNUSED, LAT_W'($urandom), LON_W'($urandom), RANK_W'($urandom));
    push_req(CMD_LOAD, BOUND_N[LAT_W-1:0], BOUND_W[LON_W-1:0], '1);
    push_req(CMD_LOAD, BOUND_S[LAT_W-1:0], BOUND_E[LON_W-1:0], '0);
    push_req(CMD_LOAD, LAT_W'(9000000), LON_W'(18000000), RANK_W'($urandom));
    push_req(CMD_LOAD, LAT_W'(-9000000), LON_W'(-18000000), RANK_W'($urandom));
    push_req(CMD_LOAD, LAT_W'(5351400), LON_W'(-11351000), '0);
    push_req(CMD_LOAD, LAT_W'(5351400), LON_W'(-11351000), '1);
    push_req(CMD_LOAD, {1'b0, {(LAT_W-1){1'b1}}}, {1'b1, {(LON_W-1){1'b0}}}, '0);
    push_req(CMD_LOAD, {1'b1, {(LAT_W-1){1'b0}}}, {1'b0, {(LON_W-1){1'b1}}}, '1);
    for (k = 0; k <= 8; k++) push_read(RANK_W'(k));
    push_read(RANK_W'(1023));
    push_req(CMD_CLEAR, '1, '1, '1);
    push_read(RANK_W'(0));
    wait_idle();

    // far cursor: saturated distance
    program_view(9'd511, 9'd511, 11'd2047, 11'd2047);
    push_req(CMD_CLEAR, '0, '0, '0);
    push_req(CMD_LOAD, BOUND_N[LAT_W-1:0], BOUND_W[LON_W-1:0], '0);
    push_req(CMD_LOAD, BOUND_S[LAT_W-1:0], BOUND_E[LON_W-1:0], '0);
    push_read(RANK_W'(0));
    push_read(RANK_W'(1));
    push_read(RANK_W'(2));
    wait_idle();

    // origin cursor, then a run of equal distances
    program_view(9'd0, 9'd0, 11'd0, 11'd0);
    push_req(CMD_LOAD, BOUND_S[LAT_W-1:0], BOUND_E[LON_W-1:0], '0);
    push_req(CMD_LOAD, BOUND_N[LAT_W-1:0], BOUND_W[LON_W-1:0], '0);
    push_read(RANK_W'(0));
    push_read(RANK_W'(1));
    push_req(CMD_CLEAR, '0, '0, '0);
    for (k = 0; k < 40; k++) begin
      lat_v = longint'(BOUND_N) + $urandom_range(0, 3000000);
      lon_v = longint'(BOUND_W) - $urandom_range(0, 6000000);
      push_req(CMD_LOAD, lat_v[LAT_W-1:0], lon_v[LON_W-1:0], RANK_W'($urandom));
    end
    push_req(CMD_LOAD, BOUND_S[LAT_W-1:0], BOUND_E[LON_W-1:0], '0);
    push_read(RANK_W'(0));
    push_read(RANK_W'(511));
    push_read(RANK_W'(1022));
    push_read(RANK_W'(1023));
    for (k = 0; k < 6; k++) push_read(RANK_W'($urandom));
    push_req(CMD_CLEAR, '0, '0, '0);
    push_read(RANK_W'(0));
    wait_idle();

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: program_view(9'($urandom), 9'($urandom), 11'($urandom), 11'($urandom));
        1: program_view(CURSOR_X_RST, CURSOR_Y_RST, VIEW_X_RST, VIEW_Y_RST);
        2: program_view(9'd419, 9'd319, 11'd2047, 11'd2047);
        3: program_view(9'd0, 9'd0, 11'd0, 11'd0);
        default: program_view(9'($urandom_range(0, 419)), 9'($urandom_range(0, 319)),
                              11'($urandom_range(600, 1100)), 11'($urandom_range(600, 1100)));
      endcase
      sender_gaps_on     = (phase != 1);
      receiver_stalls_on = (phase != 1) && (phase != 4);
      queue_random_mix(100);
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/mdrs_pkg.sv
src/mdrs_dist.sv
src/manhattan_distance_rank_sort.sv
dv/manhattan_distance_rank_sort_tb.sv
